// ===== src/colormap_interpolator_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef COLORMAP_INTERPOLATOR_UNIT_DEFINES_SVH
`define COLORMAP_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CMI_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CMI_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== src/cmi_pkg.sv =====
package cmi_pkg;

  localparam int MAX_STOPS_DEF = 8;
  localparam int POS_W = 17;
  localparam int NUM_W = 26;
  localparam int DEN_W = 18;
  localparam int CH_N = 4;
  localparam logic [POS_W-1:0] POS_ONE = 17'd65536;

  localparam logic [1:0] CFG_RANGE_MIN = 2'd0;
  localparam logic [1:0] CFG_INV_SPAN = 2'd1;
  localparam logic [1:0] CFG_STOP_COUNT = 2'd2;
  localparam logic [1:0] CFG_INVERT = 2'd3;

  typedef struct packed {
    logic valid;
    logic [DEN_W-1:0] den;
    logic [CH_N-1:0][NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic valid;
    logic [CH_N-1:0][7:0] quo;
  } div_rsp_t;

  function automatic logic [POS_W-1:0] preset_pos(input int i);
    logic [POS_W-1:0] p;
    case (i)
      0: p = 17'd0;
      1: p = 17'd26214;
      2: p = 17'd32768;
      3: p = 17'd39322;
      4: p = 17'd65536;
      default: p = '0;
    endcase
    return p;
  endfunction

  // RGBA packed red in the top byte.
  function automatic logic [31:0] preset_color(input int i);
    logic [31:0] c;
    case (i)
      0: c = {8'd0, 8'd0, 8'd255, 8'd255};
      1: c = {8'd0, 8'd255, 8'd255, 8'd255};
      2: c = {8'd0, 8'd255, 8'd0, 8'd255};
      3: c = {8'd255, 8'd255, 8'd0, 8'd255};
      4: c = {8'd255, 8'd0, 8'd0, 8'd255};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/cmi_ram.sv =====
module cmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cmi_div.sv =====
module cmi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cmi_pkg::div_req_t req,
  output cmi_pkg::div_rsp_t rsp
);

  import cmi_pkg::*;

  localparam int STAGES = 4;

  logic [CH_N-1:0][NUM_W-1:0] rem_in [STAGES];
  logic [CH_N-1:0][7:0]       quo_in [STAGES];
  logic [DEN_W-1:0]           den_in [STAGES];
  logic                       vld_in [STAGES];

  logic [CH_N-1:0][NUM_W-1:0] rem_r [STAGES];
  logic [CH_N-1:0][7:0]       quo_r [STAGES];
  logic [DEN_W-1:0]           den_r [STAGES];
  logic                       vld_r [STAGES];

  assign rem_in[0] = req.num;
  assign quo_in[0] = '0;
  assign den_in[0] = req.den;
  assign vld_in[0] = req.valid;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [CH_N-1:0][NUM_W-1:0] rem_next;
    logic [CH_N-1:0][7:0]       quo_next;

    if (s > 0) begin : g_link
      assign rem_in[s] = rem_r[s-1];
      assign quo_in[s] = quo_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign vld_in[s] = vld_r[s-1];
    end

    // two quotient bits per stage, msb first
    always_comb begin
      logic [NUM_W-1:0] r;
      logic [NUM_W-1:0] trial;
      logic [7:0] q;
      for (int ch = 0; ch < CH_N; ch++) begin
        r = rem_in[s][ch];
        q = quo_in[s][ch];
        for (int j = 0; j < 2; j++) begin
          trial = NUM_W'(den_in[s]) << (7 - 2 * s - j);
          if (r >= trial) begin
            r = r - trial;
            q[7 - 2 * s - j] = 1'b1;
          end
        end
        rem_next[ch] = r;
        quo_next[ch] = q;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_next;
        quo_r[s] <= quo_next;
        den_r[s] <= den_in[s];
      end
    end
  end

  assign rsp.valid = vld_r[STAGES-1];
  assign rsp.quo = quo_r[STAGES-1];

endmodule

// ===== src/colormap_interpolator_unit.sv =====
// A map beat's result reaches out_valid through the pipeline registers and the divider stages; stalls delay it.
// Throughput: one beat per cycle; a 32x32 normalize multiply, a parallel stop compare,
// dual color RAM reads and a 4-stage divider are all pipelined.
// A stalled output holds the whole pipeline.
// Reset (synchronous, rst high): registers to defaults, stop table to the jet preset,
// pipeline emptied; no clearing pass.
module colormap_interpolator_unit #(
  parameter int MAX_STOPS = cmi_pkg::MAX_STOPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] sample_value,
  input  logic [2:0]         stop_index,
  input  logic [16:0]        stop_position,
  input  logic [7:0]         stop_red,
  input  logic [7:0]         stop_green,
  input  logic [7:0]         stop_blue,
  input  logic [7:0]         stop_alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha
);

  import cmi_pkg::*;

  localparam int IW = $clog2(MAX_STOPS);

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  logic signed [31:0] range_min;
  logic [31:0] inv_span;
  logic [3:0] stop_count;
  logic invert_colors;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= '0;
      inv_span <= 32'd65536;
      stop_count <= 4'd5;
      invert_colors <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RANGE_MIN: range_min <= cfg_data;
        CFG_INV_SPAN: inv_span <= cfg_data;
        CFG_STOP_COUNT: stop_count <= cfg_data[3:0];
        CFG_INVERT: invert_colors <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [IW-1:0] n_last;
  always_comb begin
    if (stop_count < 4'd2) begin
      n_last = IW'(1);
    end else if (32'(stop_count) > MAX_STOPS) begin
      n_last = IW'(MAX_STOPS - 1);
    end else begin
      n_last = IW'(stop_count - 4'd1);
    end
  end

  // stage 1: input beat
  logic v1, k1;
  logic signed [31:0] smp1;
  logic [2:0] idx1;
  logic [POS_W-1:0] wpos1;
  logic [31:0] col1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= kind;
      smp1 <= sample_value;
      idx1 <= stop_index;
      wpos1 <= stop_position;
      col1 <= {stop_red, stop_green, stop_blue, stop_alpha};
    end
  end

  logic signed [32:0] diff1;
  logic le0_1;
  assign diff1 = {smp1[31], smp1} - {range_min[31], range_min};
  assign le0_1 = diff1[32] || (diff1 == '0);

  // stage 2: difference
  logic v2, k2, le0_2;
  logic [31:0] d2;
  logic [2:0] idx2;
  logic [POS_W-1:0] wpos2;
  logic [31:0] col2;

  // stage 3: product
  logic v3, k3, le0_3;
  logic [63:0] prod3;
  logic [2:0] idx3;
  logic [POS_W-1:0] wpos3;
  logic [31:0] col3;

  // stage 4: normalized value
  logic v4, k4;
  logic [POS_W-1:0] w4;
  logic [2:0] idx4;
  logic [POS_W-1:0] wpos4;
  logic [31:0] col4;

  logic [POS_W-1:0] w3;
  always_comb begin
    if (le0_3) begin
      w3 = '0;
    end else if ((|prod3[63:33]) || (prod3[32:16] > POS_ONE)) begin
      w3 = POS_ONE;
    end else begin
      w3 = prod3[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2 <= k1;
      le0_2 <= le0_1;
      d2 <= diff1[31:0];
      idx2 <= idx1;
      wpos2 <= wpos1;
      col2 <= col1;
      k3 <= k2;
      le0_3 <= le0_2;
      prod3 <= d2 * inv_span;
      idx3 <= idx2;
      wpos3 <= wpos2;
      col3 <= col2;
      k4 <= k3;
      w4 <= w3;
      idx4 <= idx3;
      wpos4 <= wpos3;
      col4 <= col3;
    end
  end

  logic [31:0] idx4_ext;
  logic idx_ok4;
  assign idx4_ext = 32'(idx4);
  assign idx_ok4 = idx4_ext < MAX_STOPS;

  // stop positions, written and compared in stage 4
  logic [POS_W-1:0] pos [MAX_STOPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STOPS; i++) begin
        pos[i] <= preset_pos(i);
      end
    end else if (en && v4 && k4 && idx_ok4) begin
      pos[idx4_ext[IW-1:0]] <= wpos4;
    end
  end

  logic [MAX_STOPS-1:0] ge4, le4;
  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      ge4[i] = pos[i] >= w4;
      le4[i] = pos[i] <= w4;
    end
  end

  // stage 5: compare results and position snapshot
  logic v5, k5;
  logic [POS_W-1:0] w5;
  logic [MAX_STOPS-1:0] ge5, le5;
  logic [POS_W-1:0] snap5 [MAX_STOPS];
  logic [2:0] idx5;
  logic [31:0] col5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k5 <= k4;
      w5 <= w4;
      ge5 <= ge4;
      le5 <= le4;
      snap5 <= pos;
      idx5 <= idx4;
      col5 <= col4;
    end
  end

  logic lo5, hi5;
  logic [MAX_STOPS-1:0] g5, h5;
  logic [POS_W-1:0] plo5, phi5;
  logic [IW-1:0] l5;

  assign lo5 = ge5[0];
  assign hi5 = le5[n_last];

  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      g5[i] = ((i >= 1) && (i < 32'(n_last)) && ge5[i]) || (i == 32'(n_last));
    end
  end

  // lowest set bit marks the first stop at or above w
  assign h5 = g5 & (~g5 + 1'b1);

  always_comb begin
    plo5 = '0;
    phi5 = '0;
    l5 = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (h5[i]) begin
        phi5 = phi5 | snap5[i];
        l5 = l5 | IW'(i);
      end
      if ((i < MAX_STOPS - 1) && h5[(i + 1) % MAX_STOPS]) begin
        plo5 = plo5 | snap5[i];
      end
    end
  end

  // stage 6: segment selected
  logic v6, k6, lo6, hi6;
  logic [POS_W-1:0] w6, plo6, phi6;
  logic [IW-1:0] l6;
  logic [2:0] idx6;
  logic [31:0] col6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k6 <= k5;
      lo6 <= lo5;
      hi6 <= hi5;
      w6 <= w5;
      plo6 <= plo5;
      phi6 <= phi5;
      l6 <= l5;
      idx6 <= idx5;
      col6 <= col5;
    end
  end

  logic [POS_W-1:0] a6, b6;
  logic [IW-1:0] ci0_6, ci1_6;

  always_comb begin
    ci0_6 = '0;
    if (lo6) begin
      a6 = POS_W'(1);
      b6 = '0;
      ci1_6 = invert_colors ? n_last : '0;
    end else if (hi6) begin
      a6 = POS_W'(1);
      b6 = '0;
      ci1_6 = invert_colors ? '0 : n_last;
    end else begin
      a6 = w6 - plo6;
      b6 = phi6 - w6;
      ci1_6 = invert_colors ? IW'(n_last - l6) : l6;
      ci0_6 = invert_colors ? IW'(n_last - l6 + 1'b1) : IW'(l6 - 1'b1);
    end
  end

  logic [31:0] idx6_ext;
  logic cwe6;
  assign idx6_ext = 32'(idx6);
  assign cwe6 = en && v6 && k6 && (idx6_ext < MAX_STOPS);

  logic [MAX_STOPS-1:0] cvalid;
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
    end else if (cwe6) begin
      cvalid[idx6_ext[IW-1:0]] <= 1'b1;
    end
  end

  logic [31:0] rd0, rd1;

  cmi_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_col0 (
    .clk   (clk),
    .we    (cwe6),
    .waddr (idx6_ext[IW-1:0]),
    .wdata (col6),
    .re    (en),
    .raddr (ci0_6),
    .rdata (rd0)
  );

  cmi_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_col1 (
    .clk   (clk),
    .we    (cwe6),
    .waddr (idx6_ext[IW-1:0]),
    .wdata (col6),
    .re    (en),
    .raddr (ci1_6),
    .rdata (rd1)
  );

  // stage 7: colors read
  logic v7, cv0_7, cv1_7;
  logic [POS_W-1:0] a7, b7;
  logic [IW-1:0] ci0_7, ci1_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6 && !k6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a7 <= a6;
      b7 <= b6;
      ci0_7 <= ci0_6;
      ci1_7 <= ci1_6;
      cv0_7 <= cvalid[ci0_6];
      cv1_7 <= cvalid[ci1_6];
    end
  end

  logic [31:0] c0_7, c1_7;
  assign c0_7 = cv0_7 ? rd0 : preset_color(int'(ci0_7));
  assign c1_7 = cv1_7 ? rd1 : preset_color(int'(ci1_7));

  div_req_t req7, req8;
  always_comb begin
    req7.valid = v7;
    req7.den = DEN_W'(a7) + DEN_W'(b7);
    for (int ch = 0; ch < CH_N; ch++) begin
      req7.num[ch] = NUM_W'(a7) * NUM_W'(c1_7[ch*8 +: 8])
                   + NUM_W'(b7) * NUM_W'(c0_7[ch*8 +: 8]);
    end
  end

  // stage 8: blend numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      req8.valid <= 1'b0;
    end else if (en) begin
      req8.valid <= req7.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req8.den <= req7.den;
      req8.num <= req7.num;
    end
  end

  div_rsp_t rsp;

  cmi_div u_div (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (req8),
    .rsp (rsp)
  );

  assign out_valid = rsp.valid;
  assign out_red = rsp.quo[3];
  assign out_green = rsp.quo[2];
  assign out_blue = rsp.quo[1];
  assign out_alpha = rsp.quo[0];

endmodule

// ===== src/cmi_checker.sv =====
`include "colormap_interpolator_unit_defines.svh"

module cmi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha
);

  `CMI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CMI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({out_red, out_green, out_blue, out_alpha}))
  `CMI_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
  `CMI_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

endmodule

bind colormap_interpolator_unit cmi_checker u_cmi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha)
);

// ===== tb/colormap_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

module colormap_interpolator_unit_tb;
  import cmi_pkg::*;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic kind;
  logic signed [31:0] sample_value;
  logic [2:0] stop_index;
  logic [16:0] stop_position;
  logic [7:0] stop_red, stop_green, stop_blue, stop_alpha;
  logic out_valid, out_ready;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  colormap_interpolator_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .sample_value(sample_value),
    .stop_index(stop_index), .stop_position(stop_position), .stop_red(stop_red),
    .stop_green(stop_green), .stop_blue(stop_blue), .stop_alpha(stop_alpha),
    .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha)
  );

  // shadow copy of the block state
  logic [31:0] sh_range_min, sh_inv_span;
  logic [3:0] sh_stop_count;
  logic sh_invert;
  logic [16:0] sh_pos [8];
  logic [7:0] sh_col [8][4];

  logic [31:0] exp_colors[$];
  int err_count = 0;
  int map_beats = 0, stop_beats = 0, color_beats = 0;
  int hold_cycles = 0;
  int rx_mode = 0;
  int burst_left = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 2000000);
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] predict_color(logic signed [31:0] s);
    logic signed [32:0] diff;
    logic [63:0] prod, a, b, num;
    logic [16:0] w;
    int n, l, c0, c1, k;
    logic [31:0] r;
    n = sh_stop_count < 2 ? 2 : (sh_stop_count > 8 ? 8 : sh_stop_count);
    n = n - 1;
    diff = {s[31], s} - {sh_range_min[31], sh_range_min};
    if (diff <= 0) begin
      w = '0;
    end else begin
      prod = ({32'd0, diff[31:0]} * {32'd0, sh_inv_span}) >> 16;
      w = (prod > 64'd65536) ? 17'd65536 : prod[16:0];
    end
    if (w <= sh_pos[0]) begin
      c0 = sh_invert ? n : 0;
      for (k = 0; k < 4; k++) r[31-8*k -: 8] = sh_col[c0][k];
    end else if (w >= sh_pos[n]) begin
      c0 = sh_invert ? 0 : n;
      for (k = 0; k < 4; k++) r[31-8*k -: 8] = sh_col[c0][k];
    end else begin
      l = 1;
      while (l < n && sh_pos[l] < w) l++;
      a = 64'(w - sh_pos[l-1]);
      b = 64'(sh_pos[l] - w);
      c1 = sh_invert ? n - l : l;
      c0 = sh_invert ? n - (l - 1) : l - 1;
      for (k = 0; k < 4; k++) begin
        num = a * sh_col[c1][k] + b * sh_col[c0][k];
        r[31-8*k -: 8] = 8'(num / (a + b));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("mismatch: %s at %0t", msg, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    logic [31:0] e;
    if (!rst && out_valid && out_ready) begin
      if (exp_colors.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = exp_colors.pop_front();
        color_beats++;
        if (out_red !== e[31:24])
          report_mismatch($sformatf("red got %0d expected %0d", out_red, e[31:24]));
        if (out_green !== e[23:16])
          report_mismatch($sformatf("green got %0d expected %0d", out_green, e[23:16]));
        if (out_blue !== e[15:8])
          report_mismatch($sformatf("blue got %0d expected %0d", out_blue, e[15:8]));
        if (out_alpha !== e[7:0])
          report_mismatch($sformatf("alpha got %0d expected %0d", out_alpha, e[7:0]));
      end
    end
  end

  // receiver stall pattern
  initial begin
    int cyc;
    cyc = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        out_ready = 0;
        hold_cycles--;
      end else begin
        case (rx_mode)
          0: out_ready = 1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          2: out_ready = (cyc % 5) < 2;
          default: out_ready = ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // caller is at a falling edge; returns at a falling edge with valid left high
  task automatic send_beat(logic k, logic [31:0] s, logic [2:0] idx, logic [16:0] p,
                           logic [31:0] rgba);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (g > 0) begin
        in_valid = 0;
        repeat (g) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1;
    kind = k;
    sample_value = s;
    stop_index = idx;
    stop_position = p;
    {stop_red, stop_green, stop_blue, stop_alpha} = rgba;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k) begin
      sh_pos[idx] = p;
      for (int j = 0; j < 4; j++) sh_col[idx][j] = rgba[31-8*j -: 8];
      stop_beats++;
    end else begin
      exp_colors.insert(exp_colors.size(), predict_color(s));
      map_beats++;
    end
    @(negedge clk);
  endtask

  task automatic send_map(logic [31:0] s);
    send_beat(1'b0, s, 3'($urandom), 17'($urandom), $urandom);
  endtask

  task automatic send_stop(logic [2:0] idx, logic [16:0] p, logic [31:0] rgba);
    send_beat(1'b1, $urandom, idx, p, rgba);
  endtask

  task automatic drain();
    in_valid = 0;
    while (exp_colors.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RANGE_MIN: sh_range_min = d;
      CFG_INV_SPAN: sh_inv_span = d;
      CFG_STOP_COUNT: sh_stop_count = d[3:0];
      CFG_INVERT: sh_invert = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic load_ascending_table();
    logic [16:0] p[8];
    logic [16:0] t;
    for (int i = 0; i < 8; i++) p[i] = $urandom_range(0, 65536);
    for (int i = 0; i < 8; i++)
      for (int j = i + 1; j < 8; j++)
        if (p[j] < p[i]) begin
          t = p[i]; p[i] = p[j]; p[j] = t;
        end
    for (int i = 0; i < 8; i++) send_stop(3'(i), p[i], $urandom);
  endtask

  task automatic test_jet_preset();
    send_map(32'h0000_0000);
    send_map(32'h8000_0000);
    send_map(32'h7FFF_FFFF);
    send_map(32'h0001_0000);
    send_map(32'h0000_4000);
    send_map(32'h0000_8000);
    send_map(32'h0000_6666);
    send_map(32'h0000_999A);
    send_map(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_invert_and_range();
    write_reg(CFG_INVERT, 32'd1);
    send_map(32'h0000_0000);
    send_map(32'h0000_C000);
    send_map(32'h0001_0000);
    drain();
    write_reg(CFG_RANGE_MIN, 32'h8000_0000);
    write_reg(CFG_INV_SPAN, 32'd1);
    send_map(32'h7FFF_FFFF);
    send_map(32'h0000_0000);
    drain();
    write_reg(CFG_INV_SPAN, 32'hFFFF_FFFF);
    send_map(32'h8000_0001);
    drain();
    write_reg(CFG_INV_SPAN, 32'd0);
    send_map(32'h1234_5678);
    drain();
    write_reg(CFG_RANGE_MIN, 32'd0);
    write_reg(CFG_INV_SPAN, 32'd65536);
    write_reg(CFG_INVERT, 32'd0);
  endtask

  task automatic test_stop_writes();
    // non-ascending positions and one beyond 1.0
    send_stop(3'd7, 17'h1FFFF, 32'hFFFF_FFFF);
    send_stop(3'd5, 17'd0, 32'h0000_0000);
    send_stop(3'd2, 17'd60000, 32'h80FF_017F);
    drain();
    for (int c = 0; c < 16; c += 5) begin
      write_reg(CFG_STOP_COUNT, 32'(c));
      send_map(32'h0000_A000);
      send_map(32'h0000_F000);
      drain();
    end
    write_reg(CFG_STOP_COUNT, 32'd8);
    send_map(32'h0000_E000);
    drain();
  endtask

  task automatic test_backpressure();
    load_ascending_table();
    drain();
    hold_cycles = 400;
    for (int i = 0; i < 150; i++) send_map($urandom_range(0, 32'h0001_2000));
    drain();
  endtask

  task automatic test_random(int total);
    int sent;
    logic [31:0] off;
    sent = 0;
    while (sent < total) begin
      drain();
      write_reg(CFG_RANGE_MIN, ($urandom_range(0, 3) == 0) ? $urandom : $urandom >> 8);
      case ($urandom_range(0, 4))
        0: write_reg(CFG_INV_SPAN, $urandom);
        1: write_reg(CFG_INV_SPAN, $urandom_range(0, 32'h4_0000));
        2: write_reg(CFG_INV_SPAN, $urandom >> $urandom_range(0, 31));
        default: write_reg(CFG_INV_SPAN, 32'd65536);
      endcase
      write_reg(CFG_STOP_COUNT, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(2, 8));
      write_reg(CFG_INVERT, $urandom);
      if ($urandom_range(0, 3) != 0) load_ascending_table();
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_stop(3'($urandom), 17'($urandom), $urandom);
        end else if ($urandom_range(0, 4) == 0) begin
          send_map($urandom);
          sent++;
        end else begin
          off = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 7) == 0) off = -off;
          send_map(sh_range_min + off);
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    rst = 1;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; kind = 0; sample_value = 0; stop_index = 0; stop_position = 0;
    stop_red = 0; stop_green = 0; stop_blue = 0; stop_alpha = 0;
    sh_range_min = 0; sh_inv_span = 32'd65536; sh_stop_count = 4'd5; sh_invert = 0;
    for (int i = 0; i < 8; i++) begin
      sh_pos[i] = preset_pos(i);
      for (int j = 0; j < 4; j++) sh_col[i][j] = 8'(preset_color(i) >> (24 - 8 * j));
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_jet_preset();
    test_invert_and_range();
    test_stop_writes();
    test_backpressure();
    test_random(1300);
    drain();
    $display("covered %0d map beats, %0d stop writes, %0d colors checked", map_beats,
             stop_beats, color_beats);
    $display("settings swept: range, span, stop count, invert, long output hold-off");
    if (err_count == 0 && exp_colors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
